// ===== sv/wbps_pkg.sv =====
package wbps_pkg;

    // Request codes carried by req_type
    localparam logic [1:0] REQ_LOAD    = 2'd0;
    localparam logic [1:0] REQ_STREAM  = 2'd1;
    localparam logic [1:0] REQ_RESTART = 2'd2;

    // Pattern byte that matches any stream byte ('b')
    localparam logic [7:0] WILDCARD_BYTE = 8'd98;

    // Effective pattern length width, enough for lengths up to 256
    localparam int LEN_W = 9;

    // Register map (byte addresses)
    localparam logic [2:0] ADDR_PATTERN_LENGTH = 3'd0;

    // Broadcast control to every cell of the chain
    typedef struct packed {
        logic step;   // a stream byte advances the matcher
        logic clear;  // restart: drop all prefix flags
    } t_cell_ctl;

endpackage

// ===== sv/wbps_cell.sv =====
module wbps_cell
    import wbps_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic             i_wr,
    input  logic [7:0]       i_byte,
    input  logic [LEN_W-1:0] i_len,
    input  logic             i_prev,
    output logic             o_flag,
    output logic             o_end_hit
);

    logic [7:0] r_pat;
    logic       r_flag;
    logic       n_flag;
    logic       w_in_use;
    logic       w_is_end;
    logic       w_eq;
    logic       w_hit;

    // Position decode against the active pattern length
    assign w_in_use = i_len > LEN_W'(IDX);
    assign w_is_end = i_len == LEN_W'(IDX + 1);

    // Byte compare, wildcard matches anything
    assign w_eq  = (r_pat == WILDCARD_BYTE) || (r_pat == i_byte);
    assign w_hit = w_in_use && w_eq && i_prev;

    always_comb begin
        n_flag = r_flag;
        if (i_ctl.clear) begin
            n_flag = 1'b0;
        end else if (i_ctl.step) begin
            n_flag = w_hit;
        end
    end

    // Prefix flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else begin
            r_flag <= n_flag;
        end
    end

    // Pattern byte, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_pat <= i_byte;
        end
    end

    assign o_flag    = r_flag;
    assign o_end_hit = w_hit && w_is_end;

endmodule

// ===== sv/wildcard_byte_pattern_search_top.sv =====
// Throughput: one transaction per cycle while the skid entry is empty; every byte updates
// all matcher cells in parallel, and a two-entry output stage (register plus skid) keeps
// input flowing while a result waits; each result is registered in that output stage.
// Reset: synchronous, active low; clears prefix flags, offset, done flag and output stage,
// sets pattern_length to 1. Pattern bytes are not reset and must be loaded before use.
module wildcard_byte_pattern_search_top
    import wbps_pkg::*;
#(
    parameter int MAX_PATTERN = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [6:0]  i_pattern_index,
    input  logic [7:0]  i_byte_value,
    input  logic        i_last_byte,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_found,
    output logic [31:0] o_match_offset,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

    logic [7:0]       r_pattern_length;
    logic [31:0]      r_offset;
    logic             r_done;
    logic             r_out_valid;
    logic             r_out_found;
    logic [31:0]      r_out_offset;
    logic             r_skid_valid;
    logic             r_skid_found;
    logic [31:0]      r_skid_offset;

    logic             w_accept;
    logic             w_step;
    logic             w_load;
    logic [LEN_W-1:0] w_len_raw;
    logic [LEN_W-1:0] w_len;
    t_cell_ctl        w_ctl;
    logic [MAX_PATTERN-1:0] w_flag;
    logic [MAX_PATTERN-1:0] w_end_hit;
    logic             w_match;
    logic             w_push;
    logic             w_pop;
    logic             w_res_found;
    logic [31:0]      w_res_offset;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= 8'd1;
        end else if (psel && penable && pwrite && (paddr[2] == ADDR_PATTERN_LENGTH[2])) begin
            r_pattern_length <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == ADDR_PATTERN_LENGTH[2]) ? {24'd0, r_pattern_length} : 32'd0;

    // Effective length: 0 acts as 1, clamp at the cell count
    assign w_len_raw = {1'b0, r_pattern_length};
    always_comb begin
        if (w_len_raw == '0) begin
            w_len = LEN_W'(1);
        end else if (w_len_raw > MAX_LEN) begin
            w_len = MAX_LEN;
        end else begin
            w_len = w_len_raw;
        end
    end

    // Request decode
    assign o_in_ready = !r_skid_valid;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load     = w_accept && (i_req_type == REQ_LOAD);
    assign w_step     = w_accept && (i_req_type == REQ_STREAM) && !r_done;
    assign w_ctl.step  = w_step;
    assign w_ctl.clear = w_accept && (i_req_type == REQ_RESTART);

    // Chain of matcher cells
    genvar k;
    generate
        for (k = 0; k < MAX_PATTERN; k++) begin : g_cell
            logic w_prev;
            logic w_wr;
            if (k == 0) begin : g_head
                assign w_prev = 1'b1;
            end else begin : g_body
                assign w_prev = w_flag[k-1];
            end
            assign w_wr = w_load && ({1'b0, i_pattern_index} == 8'(k));
            wbps_cell #(
                .IDX (k)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (w_ctl),
                .i_wr      (w_wr),
                .i_byte    (i_byte_value),
                .i_len     (w_len),
                .i_prev    (w_prev),
                .o_flag    (w_flag[k]),
                .o_end_hit (w_end_hit[k])
            );
        end
    endgenerate

    // Result of this byte
    assign w_match      = |w_end_hit;
    assign w_push       = w_step && (w_match || i_last_byte);
    assign w_res_found  = w_match;
    assign w_res_offset = w_match ? (r_offset - 32'(w_len - LEN_W'(1))) : 32'd0;

    // Offset counter and done flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= 32'd0;
            r_done   <= 1'b0;
        end else if (w_ctl.clear) begin
            r_offset <= 32'd0;
            r_done   <= 1'b0;
        end else if (w_step) begin
            r_offset <= r_offset + 32'd1;
            if (w_push) begin
                r_done <= 1'b1;
            end
        end
    end

    // Output register with skid entry
    assign w_pop = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid || (w_pop && !r_skid_valid)) begin
                r_out_valid <= w_push;
            end else if (!w_pop && w_push) begin
                r_skid_valid <= 1'b1;
            end else if (w_pop && r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || (w_pop && !r_skid_valid)) begin
            r_out_found  <= w_res_found;
            r_out_offset <= w_res_offset;
        end else if (w_pop && r_skid_valid) begin
            r_out_found  <= r_skid_found;
            r_out_offset <= r_skid_offset;
        end
        if (r_out_valid && !w_pop && !r_skid_valid) begin
            r_skid_found  <= w_res_found;
            r_skid_offset <= w_res_offset;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_found        = r_out_found;
    assign o_match_offset = r_out_offset;

endmodule

// ===== sv/wbps_checker.sv =====
module wbps_checker
    import wbps_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [1:0]  i_req_type,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic        o_found,
    input logic [31:0] o_match_offset
);

    // Output stage is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A not-found result carries a zero offset
    a_notfound_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_match_offset == 32'd0))
        else $error("not-found result with nonzero offset");

    // A new result follows an accepted stream byte
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready && (i_req_type == REQ_STREAM)))
        else $error("result without a stream transaction");

    // Input stalls only when a result was held back
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("input ready dropped without output backpressure");

    // Held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_found) && $stable(o_match_offset)))
        else $error("stalled result changed");

endmodule

bind wildcard_byte_pattern_search_top wbps_checker u_wbps_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_req_type     (i_req_type),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_found        (o_found),
    .o_match_offset (o_match_offset)
);

// ===== tb/tb_wildcard_byte_pattern_search_top.sv =====
`timescale 1ns / 1ps

module tb_wildcard_byte_pattern_search_top;
    import wbps_pkg::*;

    localparam int MAX_PAT = 128;
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1050;

    // Mirror of the matcher: pattern, shift-and prefix flags, offset and done flag
    class search_scoreboard;
        typedef struct packed {
            bit        found;
            bit [31:0] offset;
        } hit_t;

        logic [7:0]       pattern_mem [MAX_PAT];
        bit [MAX_PAT-1:0] prefix_hits;
        bit [31:0]        next_offset;
        bit               finished;
        logic [7:0]       length_reg;
        hit_t             awaited_hits [$];
        int               counted;
        int               errors;

        function new();
            prefix_hits = '0;
            next_offset = '0;
            finished = 1'b0;
            length_reg = 8'd1;
            counted = 0;
            errors = 0;
        endfunction

        // zero acts as one, anything above the store depth is clamped
        function int active_len();
            if (length_reg == 8'd0) return 1;
            if (length_reg > MAX_PAT) return MAX_PAT;
            return length_reg;
        endfunction

        // Returns 1 when the transaction changes state (not ignored)
        function bit predict_request(logic [1:0] req, logic [6:0] idx, logic [7:0] value,
                                     logic last);
            bit [MAX_PAT-1:0] nxt;
            bit [31:0] here;
            hit_t hit;
            int eff;
            case (req)
                REQ_LOAD: begin
                    pattern_mem[idx] = value;
                    return 1'b1;
                end
                REQ_RESTART: begin
                    prefix_hits = '0;
                    next_offset = '0;
                    finished = 1'b0;
                    return 1'b1;
                end
                REQ_STREAM: begin
                    if (finished) return 1'b0;
                    eff = active_len();
                    for (int k = 0; k < MAX_PAT; k++) begin
                        nxt[k] = (k < eff) &&
                                 (pattern_mem[k] == WILDCARD_BYTE || pattern_mem[k] == value) &&
                                 ((k == 0) ? 1'b1 : prefix_hits[k-1]);
                    end
                    prefix_hits = nxt;
                    here = next_offset;
                    next_offset = here + 32'd1;
                    if (nxt[eff-1]) begin
                        finished = 1'b1;
                        hit.found = 1'b1;
                        hit.offset = here - 32'(eff - 1);
                        awaited_hits.push_back(hit);
                    end else if (last) begin
                        finished = 1'b1;
                        hit.found = 1'b0;
                        hit.offset = '0;
                        awaited_hits.push_back(hit);
                    end
                    return 1'b1;
                end
                default: return 1'b0;
            endcase
        endfunction

        task report_mismatch(string what);
            errors++;
            $display("%0t: mismatch: %s", $time, what);
        endtask

        task check_hit(logic found, logic [31:0] offset);
            hit_t want;
            if (awaited_hits.size() == 0) begin
                report_mismatch($sformatf("unexpected result found=%0b offset=%0d",
                                          found, offset));
            end else begin
                want = awaited_hits.pop_front();
                if (found !== want.found)
                    report_mismatch($sformatf("found %0b, expected %0b", found, want.found));
                if (offset !== want.offset)
                    report_mismatch($sformatf("match_offset %0d, expected %0d",
                                              offset, want.offset));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_req_type;
    logic [6:0]  i_pattern_index;
    logic [7:0]  i_byte_value;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_found;
    logic [31:0] o_match_offset;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    search_scoreboard sb = new();
    bit tx_calm;
    bit rx_calm;

    wildcard_byte_pattern_search_top #(
        .MAX_PATTERN(MAX_PAT)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_req_type     (i_req_type),
        .i_pattern_index(i_pattern_index),
        .i_byte_value   (i_byte_value),
        .i_last_byte    (i_last_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_found        (o_found),
        .o_match_offset (o_match_offset),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Hard stop in case the block hangs
    initial begin
        #20_000_000;
        $display("** wildcard_byte_pattern_search_top: FAILED **");
        $finish;
    end

    // Result side: random stall after each transaction, checked against the scoreboard
    initial begin
        int stall;
        i_out_ready = 1'b0;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                sb.check_hit(o_found, o_match_offset);
                stall = rx_calm ? 0 : $urandom_range(0, 16);
                if (stall != 0) i_out_ready <= 1'b0;
            end else if (!i_out_ready) begin
                if (stall != 0) stall--;
                if (stall == 0) i_out_ready <= 1'b1;
            end
        end
    end

    // Pattern bytes lean on a small alphabet and wildcards so partial matches are common
    function automatic logic [7:0] pattern_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return WILDCARD_BYTE;
        if (r < 60) return r[0] ? 8'd97 : 8'd99;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] stream_byte(int eff);
        int r;
        r = $urandom_range(0, 3);
        if (r < 2) return sb.pattern_mem[$urandom_range(0, eff - 1)];
        if (r == 2) return $urandom_range(0, 1) ? 8'd97 : 8'd99;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly short patterns, a few long ones, now and then out-of-range values
    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 78) return 8'($urandom_range(1, 6));
        if (r < 90) return 8'($urandom_range(7, 16));
        if (r < 95) return 8'($urandom_range(17, 127));
        if (r < 97) return 8'd128;
        if (r == 97) return 8'd0;
        return 8'($urandom_range(129, 255));
    endfunction

    task automatic send_item(logic [1:0] req, logic [6:0] idx, logic [7:0] value, logic last);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 16);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_pattern_index <= idx;
        i_byte_value <= value;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
        if (sb.predict_request(req, idx, value, last)) sb.counted++;
    endtask

    // Stop sending, wait for every expected result, then allow for the output latency
    task automatic drain_outputs();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.awaited_hits.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_length(logic [7:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_PATTERN_LENGTH;
        pwdata <= {24'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.length_reg = value;
    endtask

    // One search: optional length change, some loads, an optional restart, then a stream
    task automatic run_search(int seq_no);
        int eff;
        int nbytes;
        int at;
        int k;
        bit embed;
        bit end_mark;
        logic [7:0] b;
        if (seq_no < 4 || $urandom_range(0, 3) == 0) begin
            drain_outputs();
            case (seq_no)
                0: write_length(8'd1);
                1: write_length(8'd255);
                2: write_length(8'd128);
                3: write_length(8'd0);
                default: write_length(pick_length());
            endcase
        end
        tx_calm = ($urandom_range(0, 3) == 0);
        rx_calm = ($urandom_range(0, 3) == 0);
        repeat ($urandom_range(0, 3))
            send_item(REQ_LOAD, 7'($urandom_range(0, 127)), pattern_byte(),
                      1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) != 0)
            send_item(REQ_RESTART, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        eff = sb.active_len();
        embed = ($urandom_range(0, 9) < 7);
        nbytes = embed ? eff + $urandom_range(0, 10) : $urandom_range(1, 16);
        at = embed ? $urandom_range(0, nbytes - eff) : 0;
        end_mark = ($urandom_range(0, 9) < 8);
        for (k = 0; k < nbytes; k++) begin
            if (embed && k >= at && k < at + eff && sb.pattern_mem[k-at] != WILDCARD_BYTE)
                b = sb.pattern_mem[k-at];
            else if (embed && k >= at && k < at + eff)
                b = 8'($urandom_range(0, 255));
            else
                b = stream_byte(eff);
            send_item(REQ_STREAM, 7'($urandom_range(0, 127)), b,
                      end_mark && (k == nbytes - 1));
            if ($urandom_range(0, 39) == 0)
                send_item(REQ_UNUSED, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
            // pattern changes in the middle of a search
            if ($urandom_range(0, 49) == 0)
                send_item(REQ_LOAD, 7'($urandom_range(0, eff - 1)), pattern_byte(), 1'b0);
        end
        // bytes after the search has ended
        if ($urandom_range(0, 4) == 0)
            send_item(REQ_STREAM, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));
        if ($urandom_range(0, 19) == 0) drain_outputs();
    endtask

    // Main sequence
    initial begin
        int k;
        int seq_no;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = REQ_LOAD;
        i_pattern_index = '0;
        i_byte_value = '0;
        i_last_byte = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // fill the whole store so no unwritten entry is ever read
        write_length(8'd0);
        for (k = 0; k < MAX_PAT; k++)
            send_item(REQ_LOAD, k[6:0],
                      (k == 0) ? 8'h00 : (k == MAX_PAT - 1) ? 8'hFF : pattern_byte(),
                      1'($urandom_range(0, 1)));

        // zero length acts as one: single-byte pattern 0x00
        send_item(REQ_RESTART, 7'd0, 8'h00, 1'b0);
        send_item(REQ_STREAM, 7'd127, 8'hFF, 1'b0);
        send_item(REQ_STREAM, 7'd0, 8'h00, 1'b0);
        send_item(REQ_STREAM, 7'd0, 8'h00, 1'b1);
        send_item(REQ_UNUSED, 7'd127, 8'hFF, 1'b1);
        send_item(REQ_RESTART, 7'd127, 8'hFF, 1'b1);
        send_item(REQ_STREAM, 7'd5, 8'hFF, 1'b1);
        send_item(REQ_STREAM, 7'd5, 8'h00, 1'b0);
        drain_outputs();

        // three-byte pattern with a wildcard in the middle
        write_length(8'd3);
        send_item(REQ_LOAD, 7'd0, 8'd97, 1'b0);
        send_item(REQ_LOAD, 7'd1, WILDCARD_BYTE, 1'b1);
        send_item(REQ_LOAD, 7'd2, 8'hFF, 1'b0);
        // match completes on the byte marked last
        send_item(REQ_RESTART, 7'd0, 8'h00, 1'b0);
        send_item(REQ_STREAM, 7'd0, 8'd97, 1'b0);
        send_item(REQ_STREAM, 7'd0, 8'h55, 1'b0);
        send_item(REQ_STREAM, 7'd0, 8'hFF, 1'b1);
        // overlapping partial match, hit at offset one
        send_item(REQ_RESTART, 7'd0, 8'h00, 1'b0);
        send_item(REQ_STREAM, 7'd0, 8'd97, 1'b0);
        send_item(REQ_STREAM, 7'd0, 8'd97, 1'b0);
        send_item(REQ_STREAM, 7'd0, 8'd97, 1'b0);
        send_item(REQ_STREAM, 7'd0, 8'hFF, 1'b1);

        // random searches
        seq_no = 0;
        while (sb.counted < ITEM_TARGET) begin
            run_search(seq_no);
            seq_no++;
        end

        drain_outputs();
        repeat (8) @(posedge i_clk);
        if (sb.awaited_hits.size() != 0)
            sb.report_mismatch($sformatf("%0d expected results never came",
                                         sb.awaited_hits.size()));
        if (sb.errors == 0) begin
            $display("** wildcard_byte_pattern_search_top: PASSED **");
        end else begin
            $display("** wildcard_byte_pattern_search_top: FAILED **");
        end
        $finish;
    end

endmodule
